[src/assert_macros.svh]
// assertion macros used by the rtl top level
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK_RST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

[src/edtf_pkg.sv]
// types and constants of the event digest and tier filter
// no dependencies
package edtf_pkg;

    localparam logic [63:0] DIGEST_SEED = 64'h517c_c1b7_2722_0a95;
    localparam int          KIND_CODES  = 32;
    localparam int          FOLD_BYTES  = 24;
    localparam int          CNT_W       = $clog2(FOLD_BYTES);

    typedef enum logic [1:0] {
        TIER_FORENSIC  = 2'd0,
        TIER_OPS_LIGHT = 2'd1,
        TIER_ULTRA_MIN = 2'd2
    } t_tier;

    typedef enum logic {
        REQ_EMIT    = 1'b0,
        REQ_RESTART = 1'b1
    } t_req;

    localparam logic CFG_TIER = 1'b0;
    localparam logic CFG_MASK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  kind;
        logic [63:0] entity;
        logic [63:0] aux;
    } t_edtf_in;

    typedef struct packed {
        logic        retained;
        logic [4:0]  out_kind;
        logic [63:0] out_entity;
        logic [63:0] out_aux;
        logic [63:0] digest_now;
        logic [31:0] emitted_total;
        logic [31:0] filtered_total;
    } t_edtf_out;

endpackage

[src/edtf_fnv_step.sv]
// one fnv-1a byte round: xor the byte in, multiply by the 64-bit prime
// prime is 2^40 + 0x1b3, so the product is a shift plus a small constant multiply
module edtf_fnv_step (
    input  logic [63:0] i_digest,
    input  logic [7:0]  i_byte,
    output logic [63:0] o_digest
);
    logic [63:0] w_mix;

    assign w_mix    = i_digest ^ {56'd0, i_byte};
    assign o_digest = {w_mix[23:0], 40'd0} + (w_mix * {55'd0, 9'h1b3});

endmodule

[src/event_digest_and_tier_filter_top.sv]
// event digest and tier filter, top level
// depends on edtf_pkg, edtf_fnv_step and assert_macros.svh
//
// usage
//   input channel i_in_valid / o_in_ready carries one request: an emit event or
//   a restart. output channel o_out_valid / i_out_ready carries one result per
//   request. config writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at
//   once and must only happen while the block is idle.
//   an emit request folds 24 bytes into the digest, one byte per cycle through
//   a single fnv round unit in the hash state; the result then passes through
//   the done state into the output register. the block takes no new request
//   until that result is registered. a restart needs no folding: it goes from
//   idle straight to the done state.
//   the block takes the next request while a finished result still waits in
//   the output register; a new result waits in a done state until the
//   receiver takes the old one, and no request is lost while stalled.
//   synchronous reset restores tier forensic, mask zero, digest seed and
//   zero counters, and empties the output register.
module event_digest_and_tier_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  edtf_pkg::t_edtf_in  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output edtf_pkg::t_edtf_out o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import edtf_pkg::*;
    `include "assert_macros.svh"

    t_state            r_state, n_state;
    t_tier             r_tier;
    logic [31:0]       r_mask;
    logic [63:0]       r_digest;
    logic [31:0]       r_seq;
    logic [31:0]       r_emitted;
    logic [31:0]       r_filtered;
    logic [8*FOLD_BYTES-1:0] r_bytes;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_keep;
    logic [4:0]        r_kind;
    logic [63:0]       r_entity;
    logic [63:0]       r_aux;
    logic              r_out_valid;
    t_edtf_out         r_out;

    logic              w_accept;
    logic              w_last;
    logic              w_load_out;
    logic              w_kept;
    logic [63:0]       w_round;
    t_edtf_out         w_result;

    edtf_fnv_step u_fnv (
        .i_digest (r_digest),
        .i_byte   (r_bytes[7:0]),
        .o_digest (w_round)
    );

    assign w_accept = i_in_valid && o_in_ready;
    assign w_last   = (r_cnt == CNT_W'(FOLD_BYTES - 1));

    always_comb begin
        case (r_tier)
            TIER_FORENSIC:  w_kept = 1'b1;
            TIER_OPS_LIGHT: w_kept = (int'(i_in.kind) < KIND_CODES) && r_mask[i_in.kind];
            default:        w_kept = 1'b0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_in.req_type == REQ_RESTART) ? ST_DONE : ST_HASH;
                end
            end
            ST_HASH: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tier <= TIER_FORENSIC;
            r_mask <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TIER) begin
                if (i_cfg_data[1:0] <= TIER_ULTRA_MIN) begin
                    r_tier <= t_tier'(i_cfg_data[1:0]);
                end
            end else if (i_cfg_index == CFG_MASK) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // digest and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest   <= DIGEST_SEED;
            r_seq      <= '0;
            r_emitted  <= '0;
            r_filtered <= '0;
            r_cnt      <= '0;
            r_keep     <= 1'b0;
        end else if (w_accept) begin
            r_cnt <= '0;
            if (i_in.req_type == REQ_RESTART) begin
                r_digest <= DIGEST_SEED;
                r_seq    <= '0;
                r_keep   <= 1'b0;
            end else begin
                r_keep <= w_kept;
            end
        end else if (r_state == ST_HASH) begin
            r_digest <= w_round;
            r_cnt    <= w_last ? '0 : r_cnt + CNT_W'(1);
            if (w_last) begin
                r_seq     <= r_seq + 32'd1;
                r_emitted <= r_emitted + 32'd1;
                if (!r_keep) begin
                    r_filtered <= r_filtered + 32'd1;
                end
            end
        end
    end

    // byte shifter and event hold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bytes  <= {i_in.aux, i_in.entity, 27'd0, i_in.kind, r_seq};
            r_kind   <= i_in.kind;
            r_entity <= i_in.entity;
            r_aux    <= i_in.aux;
        end else if (r_state == ST_HASH) begin
            r_bytes <= {8'd0, r_bytes[8*FOLD_BYTES-1:8]};
        end
    end

    always_comb begin
        w_result.retained       = r_keep;
        w_result.out_kind       = r_keep ? r_kind : 5'd0;
        w_result.out_entity     = r_keep ? r_entity : 64'd0;
        w_result.out_aux        = r_keep ? r_aux : 64'd0;
        w_result.digest_now     = r_digest;
        w_result.emitted_total  = r_emitted;
        w_result.filtered_total = r_filtered;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_CLK_RST(a_restart_seed, i_clk, i_rst_n,
        (w_accept && i_in.req_type == REQ_RESTART) |=> (r_digest == DIGEST_SEED && r_seq == '0))
    `ASSERT_CLK_RST(a_cnt_range, i_clk, i_rst_n, (r_cnt <= CNT_W'(FOLD_BYTES - 1)))
    `ASSERT_CLK_RST(a_emit_on_last, i_clk, i_rst_n,
        (r_emitted != $past(r_emitted)) |-> $past(r_state == ST_HASH && w_last))
    `ASSERT_CLK_RST(a_filter_with_emit, i_clk, i_rst_n,
        (r_filtered != $past(r_filtered)) |-> (r_emitted != $past(r_emitted)))
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

[tb/sv/tb_top.sv]
// testbench for the event digest and tier filter: random and directed requests
// checked result by result against an in-bench digest and retention predictor
// depends on edtf_pkg and event_digest_and_tier_filter_top
`timescale 1ns / 100ps

module tb_top;
    import edtf_pkg::*;

    localparam logic [63:0] FNV_PRIME     = 64'h0000_0100_0000_01b3;
    localparam logic [31:0] TIER_RESERVED = 32'd3;
    localparam int          TAIL_CYCLES   = 30;
    localparam int          SEGMENTS      = 13;
    localparam int          SEG_REQS      = 100;
    localparam int          LONG_HOLD     = 400;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_edtf_in    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_edtf_out   o_out;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_TIER;
    logic [31:0] i_cfg_data  = '0;

    t_edtf_in    pending_reqs[$];
    t_edtf_out   results_due[$];
    logic        in_fire = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_target = 0;
    int          rx_held_cnt = 0;
    int          mismatch_cnt = 0;

    // predictor state
    logic [63:0] m_digest    = DIGEST_SEED;
    logic [31:0] m_seq       = '0;
    logic [31:0] m_emitted   = '0;
    logic [31:0] m_filtered  = '0;
    t_tier       m_tier      = TIER_FORENSIC;
    logic [31:0] m_keep_mask = '0;

    event_digest_and_tier_filter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [63:0] w, int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            h = (h ^ {56'd0, w[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic t_edtf_out digest_and_filter(t_edtf_in rq);
        t_edtf_out r;
        logic      keep;
        r    = '0;
        keep = 1'b0;
        if (rq.req_type == REQ_RESTART) begin
            m_digest = DIGEST_SEED;
            m_seq    = '0;
        end else begin
            m_digest = fnv_fold(m_digest, {32'd0, m_seq}, 4);
            m_digest = fnv_fold(m_digest, {59'd0, rq.kind}, 4);
            m_digest = fnv_fold(m_digest, rq.entity, 8);
            m_digest = fnv_fold(m_digest, rq.aux, 8);
            m_seq     = m_seq + 32'd1;
            m_emitted = m_emitted + 32'd1;
            case (m_tier)
                TIER_FORENSIC:  keep = 1'b1;
                TIER_OPS_LIGHT: keep = (int'(rq.kind) < KIND_CODES) && m_keep_mask[rq.kind];
                default:        keep = 1'b0;
            endcase
            if (!keep) begin
                m_filtered = m_filtered + 32'd1;
            end
        end
        if (keep) begin
            r.retained   = 1'b1;
            r.out_kind   = rq.kind;
            r.out_entity = rq.entity;
            r.out_aux    = rq.aux;
        end
        r.digest_now     = m_digest;
        r.emitted_total  = m_emitted;
        r.filtered_total = m_filtered;
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_edtf_in random_req();
        t_edtf_in r;
        r.req_type = ($urandom_range(99) < 8) ? REQ_RESTART : REQ_EMIT;
        r.kind     = 5'($urandom_range(31));
        r.entity   = rand_word();
        r.aux      = rand_word();
        return r;
    endfunction

    task automatic queue_req(t_req rt, logic [4:0] k, logic [63:0] ent, logic [63:0] ax);
        t_edtf_in r;
        r.req_type = rt;
        r.kind     = k;
        r.entity   = ent;
        r.aux      = ax;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TIER) begin
            if (val[1:0] != TIER_RESERVED[1:0]) begin
                m_tier = t_tier'(val[1:0]);
            end
        end else begin
            m_keep_mask = val;
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_result(t_edtf_out got, t_edtf_out want);
        if (got.retained !== want.retained || got.out_kind !== want.out_kind
                || got.out_entity !== want.out_entity || got.out_aux !== want.out_aux
                || got.digest_now !== want.digest_now
                || got.emitted_total !== want.emitted_total
                || got.filtered_total !== want.filtered_total) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("mismatch expected: ret %0d kind %0d ent %h aux %h dig %h emit %0d filt %0d",
                         want.retained, want.out_kind, want.out_entity, want.out_aux,
                         want.digest_now, want.emitted_total, want.filtered_total);
                $display("         actual:   ret %0d kind %0d ent %h aux %h dig %h emit %0d filt %0d",
                         got.retained, got.out_kind, got.out_entity, got.out_aux,
                         got.digest_now, got.emitted_total, got.filtered_total);
            end
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        logic     v;
        t_edtf_in d;
        v = i_in_valid;
        d = i_in;
        if (v && in_fire) begin
            v = 1'b0;
        end
        if (!v && pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            d = pending_reqs.pop_front();
            v = 1'b1;
        end
        i_in_valid <= v;
        i_in       <= d;
    end

    // result receiver, with its own long hold-off counter
    always @(negedge i_clk) begin
        if (rx_held_cnt < rx_hold_target) begin
            rx_held_cnt <= rx_held_cnt + 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("unexpected result, digest %h", o_out.digest_now);
                    end
                end else begin
                    compare_result(o_out, results_due.pop_front());
                end
            end
            if (i_in_valid && o_in_ready) begin
                results_due.push_back(digest_and_filter(i_in));
            end
        end
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int seg;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // forensic tier from reset, field extremes and a restart
        queue_req(REQ_EMIT, 5'd0, '0, '0);
        queue_req(REQ_EMIT, 5'd31, '1, '1);
        queue_req(REQ_EMIT, 5'd10, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        queue_req(REQ_EMIT, 5'd21, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        queue_req(REQ_RESTART, 5'd31, '1, '1);
        queue_req(REQ_EMIT, 5'd1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        drain();

        // ops light, kept and dropped kinds
        write_reg(CFG_TIER, 32'(TIER_OPS_LIGHT));
        write_reg(CFG_MASK, 32'ha5a5_5a5a);
        queue_req(REQ_EMIT, 5'd0, 64'h1, 64'h2);
        queue_req(REQ_EMIT, 5'd1, 64'h3, 64'h4);
        queue_req(REQ_EMIT, 5'd3, 64'h5, 64'h6);
        queue_req(REQ_EMIT, 5'd30, 64'h7, 64'h8);
        queue_req(REQ_EMIT, 5'd31, 64'h9, 64'ha);
        drain();
        write_reg(CFG_MASK, '1);
        queue_req(REQ_EMIT, 5'd16, '1, '0);
        drain();

        // ultra minimal, then a reserved tier write that must not stick
        write_reg(CFG_TIER, 32'(TIER_ULTRA_MIN));
        queue_req(REQ_EMIT, 5'd5, 64'hdead_beef_0000_0001, 64'h0);
        queue_req(REQ_RESTART, 5'd0, '0, '0);
        queue_req(REQ_EMIT, 5'd7, '1, 64'hcafe);
        drain();
        write_reg(CFG_TIER, TIER_RESERVED);
        queue_req(REQ_EMIT, 5'd9, 64'h42, 64'h43);
        drain();
        write_reg(CFG_TIER, 32'(TIER_FORENSIC));
        write_reg(CFG_MASK, '0);
        queue_req(REQ_EMIT, 5'd2, 64'h44, 64'h45);
        drain();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 7;  rx_stall_pct = 7;  end
            endcase
            write_reg(CFG_TIER, seg % 3);
            case (seg % 4)
                0:       write_reg(CFG_MASK, '0);
                1:       write_reg(CFG_MASK, '1);
                default: write_reg(CFG_MASK, $urandom);
            endcase
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_TIER, TIER_RESERVED);
            end
            repeat (SEG_REQS) pending_reqs.push_back(random_req());
            if (seg == 4) begin
                // receiver holds off while requests keep coming
                @(posedge i_clk);
                rx_hold_target <= rx_hold_target + LONG_HOLD;
            end
            drain();
        end

        if (mismatch_cnt == 0 && results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/edtf_pkg.sv
src/edtf_fnv_step.sv
src/event_digest_and_tier_filter_top.sv
tb/sv/tb_top.sv
